@@ rtl/keyword_lexer_core_defines.svh @@
// assertion macros for the keyword lexer checker
`ifndef KEYWORD_LEXER_CORE_DEFINES_SVH
`define KEYWORD_LEXER_CORE_DEFINES_SVH

// property checked only while out of reset
`define KLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds through reset
`define KLC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/kl_pkg.sv @@
`default_nettype none
package kl_pkg;

  // longest source the position counter tracks
  localparam int MaxSource   = 65536;
  localparam int PosLimitInt = (MaxSource - 1 < 65535) ? MaxSource - 1 : 65535;
  localparam logic [15:0] PosLimit = 16'(PosLimitInt);

  // token queue depth, in records
  localparam int QDepth = 4;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    KIND_FUNCTION = 4'd0,
    KIND_LET      = 4'd1,
    KIND_TYPE     = 4'd2,
    KIND_RETURN   = 4'd3,
    KIND_EQ       = 4'd4,
    KIND_NUMBER   = 4'd5,
    KIND_IDENT    = 4'd6,
    KIND_SEMI     = 4'd7,
    KIND_COLON    = 4'd8,
    KIND_EOF      = 4'd9,
    KIND_UNKNOWN  = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // what one accepted request leaves for the back end: one or two tokens
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // keywords, padded with spaces; bytes past the length are never compared
  localparam logic [63:0] KwText [4] = '{"function", "let     ", "type    ", "return  "};
  localparam logic [3:0]  KwLen  [4] = '{4'd8, 4'd3, 4'd4, 4'd6};
  localparam kind_t       KwKind [4] = '{KIND_FUNCTION, KIND_LET, KIND_TYPE, KIND_RETURN};

  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChUnder = 8'h5f;

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) ||
           (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
  endfunction

  // keywords that still match after byte c lands at offset wl
  function automatic logic [3:0] kw_keep(input logic [3:0] mask, input logic [3:0] wl,
                                         input logic [7:0] c);
    logic [3:0] res;
    res = mask;
    for (int k = 0; k < 4; k++) begin
      if (!((wl < KwLen[k]) && (KwText[k][8 * (7 - int'(wl[2:0])) +: 8] == c))) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/kl_ifs.sv @@
`default_nettype none
interface kl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

interface kl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        is_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output is_last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/kl_front.sv @@
`default_nettype none
module kl_front (
  input  logic           clk,
  input  logic           rst_n,
  kl_in_if.sink          in_chan,
  input  kl_pkg::q_stat_t q_stat,
  output logic           push,
  output kl_pkg::rec_t   push_rec
);
  import kl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_WORD   = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] bp_r, bp_nxt;
  logic [15:0] tb_r, tb_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [3:0]  wl_r, wl_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [15:0] diff;
  logic [15:0] run_len;
  kind_t       word_kind;
  kind_t       single_kind;
  logic        do_flush;
  logic        has_second;
  tok_t        flush_tok;
  tok_t        second_tok;

  assign in_chan.ready = !q_stat.full;
  assign accept = in_chan.valid && in_chan.ready;
  assign c      = in_chan.ch;

  assign diff    = (bp_r >= tb_r) ? (bp_r - tb_r) : 16'd0;
  assign run_len = (diff == 16'd0) ? 16'd1 : diff;

  always_comb begin
    word_kind = KIND_IDENT;
    for (int k = 3; k >= 0; k--) begin
      if (mask_r[k] && (wl_r == KwLen[k])) begin
        word_kind = KwKind[k];
      end
    end
  end

  always_comb begin
    if (c == ChEq) begin
      single_kind = KIND_EQ;
    end else if (c == ChSemi) begin
      single_kind = KIND_SEMI;
    end else if (c == ChColon) begin
      single_kind = KIND_COLON;
    end else begin
      single_kind = KIND_UNKNOWN;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    bp_nxt     = bp_r;
    tb_nxt     = tb_r;
    mask_nxt   = mask_r;
    wl_nxt     = wl_r;
    do_flush   = 1'b0;
    has_second = 1'b0;

    flush_tok.start  = tb_r;
    flush_tok.length = run_len;
    flush_tok.last   = 1'b0;
    case (mode_r)
      MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
      MODE_WORD:   flush_tok.kind = word_kind;
      default:     flush_tok.kind = KIND_UNKNOWN;
    endcase

    second_tok.kind   = single_kind;
    second_tok.start  = bp_r;
    second_tok.length = 16'd1;
    second_tok.last   = 1'b0;

    if (accept) begin
      if (in_chan.end_of_source) begin
        do_flush          = (mode_r == MODE_NUMBER) || (mode_r == MODE_WORD);
        has_second        = 1'b1;
        second_tok.kind   = KIND_EOF;
        second_tok.length = 16'd0;
        second_tok.last   = 1'b1;
        mode_nxt = MODE_IDLE;
        bp_nxt   = 16'd0;
        tb_nxt   = 16'd0;
        mask_nxt = 4'hf;
        wl_nxt   = 4'd0;
      end else begin
        if ((mode_r == MODE_NUMBER) && is_num_char(c)) begin
          // number keeps growing
        end else if ((mode_r == MODE_WORD) &&
                     (is_letter(c) || is_num_char(c) || (c == ChUnder))) begin
          mask_nxt = kw_keep(mask_r, wl_r, c);
          wl_nxt   = (wl_r < 4'd9) ? wl_r + 4'd1 : wl_r;
        end else begin
          do_flush = (mode_r == MODE_NUMBER) || (mode_r == MODE_WORD);
          mode_nxt = MODE_IDLE;
          if (is_space(c)) begin
            // skipped
          end else if (is_num_char(c)) begin
            mode_nxt = MODE_NUMBER;
            tb_nxt   = bp_r;
          end else if (is_letter(c)) begin
            mode_nxt = MODE_WORD;
            tb_nxt   = bp_r;
            mask_nxt = kw_keep(4'hf, 4'd0, c);
            wl_nxt   = 4'd1;
          end else begin
            has_second = 1'b1;
          end
        end
        if (bp_r < PosLimit) begin
          bp_nxt = bp_r + 16'd1;
        end
      end
    end
  end

  assign push          = accept && (do_flush || has_second);
  assign push_rec.tok0 = do_flush ? flush_tok : second_tok;
  assign push_rec.tok1 = second_tok;
  assign push_rec.two  = do_flush && has_second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      bp_r   <= 16'd0;
      tb_r   <= 16'd0;
      mask_r <= 4'hf;
      wl_r   <= 4'd0;
    end else begin
      mode_r <= mode_nxt;
      bp_r   <= bp_nxt;
      tb_r   <= tb_nxt;
      mask_r <= mask_nxt;
      wl_r   <= wl_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kl_fifo.sv @@
`default_nettype none
module kl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kl_pkg::rec_t    push_rec,
  input  logic            pop,
  output kl_pkg::rec_t    head_rec,
  output kl_pkg::q_stat_t stat
);
  import kl_pkg::*;

  rec_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_rec   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kl_back.sv @@
`default_nettype none
module kl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  kl_pkg::rec_t    head_rec,
  input  kl_pkg::q_stat_t q_stat,
  output logic            pop,
  kl_out_if.source        out_chan
);
  import kl_pkg::*;

  rec_t rec_r, rec_nxt;
  logic valid_r, valid_nxt;
  logic idx_r, idx_nxt;
  logic fire;
  tok_t cur;

  assign fire = valid_r && out_chan.ready;
  assign cur  = idx_r ? rec_r.tok1 : rec_r.tok0;

  assign out_chan.valid        = valid_r;
  assign out_chan.token_kind   = cur.kind;
  assign out_chan.token_start  = cur.start;
  assign out_chan.token_length = cur.length;
  assign out_chan.is_last      = cur.last;

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    if (fire && !idx_r && rec_r.two) begin
      idx_nxt = 1'b1;
    end else if (!valid_r || fire) begin
      // record done or slot empty: pull the next one from the queue
      valid_nxt = !q_stat.empty;
      idx_nxt   = 1'b0;
      pop       = !q_stat.empty;
      if (!q_stat.empty) begin
        rec_nxt = head_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/keyword_lexer_core.sv @@
`default_nettype none
// channel    dir  handshake     payload
// in_chan    in   valid/ready   ch[7:0], end_of_source
// out_chan   out  valid/ready   token_kind[3:0], token_start[15:0],
//                               token_length[15:0], is_last
//
// one input request per cycle while the token queue has room
// valid rises via the queue and output register; one token per cycle unless stalled
// a request that closes a token and makes another queues a two-token record
// rst_n is synchronous; scanner state, queue pointers and output valid clear
// out_chan stalls fill the token queue, then in_chan.ready drops
module keyword_lexer_core (
  input  logic   clk,
  input  logic   rst_n,
  kl_in_if.sink  in_chan,
  kl_out_if.source out_chan
);
  import kl_pkg::*;

  // front to queue
  logic    push;
  rec_t    push_rec;
  // queue to back
  logic    pop;
  rec_t    head_rec;
  q_stat_t q_stat;

  // front: classifies each byte, tracks the open token, builds token records
  kl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  // short record queue so scanner and output can stall on their own
  kl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  // back: output register, hands out one token of a record per cycle unless stalled
  kl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

@@ rtl/kl_checker.sv @@
`default_nettype none
`include "keyword_lexer_core_defines.svh"
module kl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [15:0] out_start,
  input logic [15:0] out_length,
  input logic        out_is_last
);
  import kl_pkg::*;

  `KLC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_start) && $stable(out_length) && $stable(out_is_last)), "stalled token changed")
  `KLC_ASSERT(a_last_is_eof, clk, rst_n, (out_valid && out_is_last |-> out_kind == KIND_EOF && out_length == 16'd0), "last token is not an empty eof")
  `KLC_ASSERT(a_body_tok, clk, rst_n, (out_valid && !out_is_last |-> out_kind != KIND_EOF && out_length != 16'd0), "eof or empty token not marked last")
  `KLC_ASSERT_NR(a_reset_idle, clk, (!rst_n |=> !out_valid), "output valid after reset")

endmodule

bind keyword_lexer_core kl_checker u_kl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_kind    (out_chan.token_kind),
  .out_start   (out_chan.token_start),
  .out_length  (out_chan.token_length),
  .out_is_last (out_chan.is_last)
);
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
module testbench;
  import kl_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_ITEMS = 680;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 16;

  // whitespace bytes: space, tab, newline, vertical tab, form feed, carriage return
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

  // scanner modes of the predictor
  typedef enum logic [1:0] {SCAN_GAP, SCAN_NUMBER, SCAN_WORD} scan_t;

  logic clk = 1'b0;
  logic rst_n;

  kl_in_if  in_chan ();
  kl_out_if out_chan ();

  keyword_lexer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keyword spellings and the kinds they map to
  string kw_word [4] = '{"function", "let", "type", "return"};
  kind_t kw_kind [4] = '{KIND_FUNCTION, KIND_LET, KIND_TYPE, KIND_RETURN};

  // predictor state
  scan_t       scan_mode = SCAN_GAP;
  logic [15:0] lex_pos = '0;
  logic [15:0] tok_begin = '0;
  logic [3:0]  kw_alive = 4'hf;
  logic [3:0]  word_len = '0;

  // tokens predicted but not yet seen on the output
  tok_t tokens_due [$];

  int  errors = 0;
  int  items_sent = 0;
  int  rx_wait = 0;
  int  cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  logic hold_off = 1'b0;
  event stall_go;

  // byte classes
  function automatic logic ch_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic ch_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic ch_blank(input logic [7:0] c);
    return c inside {BLANKS[0], BLANKS[1], BLANKS[2], BLANKS[3], BLANKS[4], BLANKS[5]};
  endfunction

  function automatic logic ch_word(input logic [7:0] c);
    return ch_letter(c) || ch_digit(c) || (c == ChUnder);
  endfunction

  function automatic void push_token(input kind_t k, input logic [15:0] s,
                                     input logic [15:0] n, input logic last);
    tok_t t;
    t.kind   = k;
    t.start  = s;
    t.length = n;
    t.last   = last;
    tokens_due.push_back(t);
  endfunction

  // run length from saturated positions, never below one
  function automatic logic [15:0] run_len();
    logic [15:0] d;
    d = (lex_pos >= tok_begin) ? lex_pos - tok_begin : 16'd0;
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  // drop keywords that the new byte rules out, count the word up to nine
  function automatic void track_keyword(input logic [7:0] c);
    for (int i = 0; i < 4; i++) begin
      if (!(word_len < kw_word[i].len() && kw_word[i][word_len] == c)) begin
        kw_alive[i] = 1'b0;
      end
    end
    if (word_len < 4'd9) begin
      word_len++;
    end
  endfunction

  // emit the open number or word, if any
  function automatic void close_token();
    kind_t k;
    if (scan_mode == SCAN_NUMBER) begin
      push_token(KIND_NUMBER, tok_begin, run_len(), 1'b0);
    end else if (scan_mode == SCAN_WORD) begin
      k = KIND_IDENT;
      for (int i = 3; i >= 0; i--) begin
        if (kw_alive[i] && word_len == kw_word[i].len()) begin
          k = kw_kind[i];
        end
      end
      push_token(k, tok_begin, run_len(), 1'b0);
    end
    scan_mode = SCAN_GAP;
  endfunction

  // predict the tokens that one accepted request produces
  function automatic void lex_byte(input logic [7:0] c, input logic eos);
    kind_t k;
    if (eos) begin
      // end of source: flush, eof token, then a fresh source
      close_token();
      push_token(KIND_EOF, lex_pos, 16'd0, 1'b1);
      scan_mode = SCAN_GAP;
      lex_pos   = '0;
      tok_begin = '0;
      kw_alive  = 4'hf;
      word_len  = '0;
      return;
    end
    if (scan_mode == SCAN_NUMBER && ch_digit(c)) begin
      // number grows
    end else if (scan_mode == SCAN_WORD && ch_word(c)) begin
      track_keyword(c);
    end else begin
      close_token();
      if (ch_blank(c)) begin
        // skipped
      end else if (ch_digit(c)) begin
        scan_mode = SCAN_NUMBER;
        tok_begin = lex_pos;
      end else if (ch_letter(c)) begin
        scan_mode = SCAN_WORD;
        tok_begin = lex_pos;
        kw_alive  = 4'hf;
        word_len  = '0;
        track_keyword(c);
      end else begin
        // one-byte tokens; anything unrecognized is unknown
        case (c)
          ChEq:    k = KIND_EQ;
          ChSemi:  k = KIND_SEMI;
          ChColon: k = KIND_COLON;
          default: k = KIND_UNKNOWN;
        endcase
        push_token(k, lex_pos, 16'd1, 1'b0);
      end
    end
    // position saturates at the limit
    if (lex_pos < PosLimit) begin
      lex_pos++;
    end
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endtask

  // offer one request, wait for the handshake, then predict
  task automatic send_item(input logic [7:0] c, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.ch            <= c;
    in_chan.end_of_source <= eos;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    lex_byte(c, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return pick_letter();
    end else if (r < 9) begin
      return pick_digit();
    end
    return ChUnder;
  endfunction

  // one token-shaped chunk of source, mostly well formed, some noise
  task automatic send_piece();
    int    n;
    int    idx;
    int    how;
    string w;
    case ($urandom_range(0, 11))
      0, 1: send_text(kw_word[$urandom_range(0, 3)]);
      2: begin
        // near miss: shortened, one capital, or extended keyword
        w   = kw_word[$urandom_range(0, 3)];
        how = $urandom_range(0, 2);
        if (how == 0) begin
          w = w.substr(0, w.len() - 2);
        end else if (how == 1) begin
          idx = $urandom_range(0, w.len() - 1);
          w[idx] = w[idx] - 8'h20;
        end
        send_text(w);
        if (how == 2) begin
          send_item(pick_word_char(), 1'b0);
        end
      end
      3, 4: begin
        send_item(pick_letter(), 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) send_item(pick_word_char(), 1'b0);
      end
      5: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(pick_digit(), 1'b0);
      end
      6: begin
        // letter right after digits splits into number and word
        n = $urandom_range(1, 4);
        repeat (n) send_item(pick_digit(), 1'b0);
        n = $urandom_range(1, 5);
        repeat (n) send_item(pick_letter(), 1'b0);
      end
      7: begin
        how = $urandom_range(0, 2);
        send_item((how == 0) ? ChEq : (how == 1) ? ChSemi : ChColon, 1'b0);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(BLANKS[$urandom_range(0, 5)], 1'b0);
      end
      9: send_item(8'($urandom_range(0, 255)), 1'b0);
      10: begin
        // underscore cannot start a word
        send_item(ChUnder, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) send_item(pick_word_char(), 1'b0);
      end
      default: begin
        // long word, past the saturating word counter
        w = kw_word[$urandom_range(0, 3)];
        send_text(w);
        n = $urandom_range(9, 14) - w.len();
        repeat (n) send_item(pick_word_char(), 1'b0);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      send_item(BLANKS[$urandom_range(0, 5)], 1'b0);
    end
  endtask

  // a whole source: some pieces then the end request, sometimes empty
  task automatic send_source(input int max_pieces);
    int n;
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_pieces);
    repeat (n) send_piece();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // operators, zero and top bytes, every blank, digit-letter split,
  // lone underscore, keyword flushed by end of source, empty source
  task automatic test_directed();
    send_text("let 7q=_;:");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    foreach (BLANKS[i]) send_item(BLANKS[i], 1'b0);
    send_text("type");
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  // random sources with idling switched on and off per source
  task automatic test_random_sources();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_source(12);
    end
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    int first;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    first   = items_sent;
    -> stall_go;
    while (items_sent - first < 60) send_piece();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold-off counter for the pressure test
  initial begin
    forever begin
      @(stall_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // result side: compare each token with the oldest prediction, then pick a stall
  initial begin : token_checker
    tok_t want;
    logic bad;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        if (tokens_due.size() == 0) begin
          flag_error($sformatf("unexpected token: kind %0d start %0d length %0d last %0b",
                               out_chan.token_kind, out_chan.token_start,
                               out_chan.token_length, out_chan.is_last));
        end else begin
          want = tokens_due.pop_front();
          bad  = (out_chan.token_kind !== want.kind) ||
                 (out_chan.token_start !== want.start) ||
                 (out_chan.token_length !== want.length) ||
                 (out_chan.is_last !== want.last);
          if (bad) begin
            flag_error($sformatf(
                "token mismatch: expected kind %0d start %0d length %0d last %0b, got kind %0d start %0d length %0d last %0b",
                want.kind, want.start, want.length, want.last,
                out_chan.token_kind, out_chan.token_start,
                out_chan.token_length, out_chan.is_last));
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
      end
      if (hold_off || rx_wait != 0) begin
        out_chan.ready <= 1'b0;
        if (rx_wait != 0) begin
          rx_wait--;
        end
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.ch            <= 8'h00;
    in_chan.end_of_source <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_sources();
    test_backpressure();

    in_chan.valid <= 1'b0;
    // drain, then watch a little longer for stray tokens
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tokens_due.size() != 0) begin
      flag_error($sformatf("%0d predicted tokens never arrived", tokens_due.size()));
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
